// ===== hw/rtl/pbbg_pkg.sv =====
// Shared types, constants and helper functions for the power button and battery gauge.
`timescale 1ns / 1ps
package pbbg_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLIP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_STEP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MV   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV    = 3'd7;

    localparam logic [15:0] RST_DEBOUNCE   = 16'd4;
    localparam logic [15:0] RST_WINDOW     = 16'd800;
    localparam logic [15:0] RST_LONG_PRESS = 16'd240;
    localparam logic [15:0] RST_BLIP       = 16'd40;
    localparam logic [13:0] RST_ANIM_STEP  = 14'd60;
    localparam logic [15:0] RST_BLINK_HALF = 16'd50;
    localparam logic [11:0] RST_EMPTY_MV   = 12'd2310;
    localparam logic [11:0] RST_FULL_MV    = 12'd3000;

    localparam logic [11:0] ADC_FULL_CODE = 12'd4095;
    localparam logic [11:0] VREF_MV       = 12'd3300;
    localparam logic [6:0]  PCT_FULL      = 7'd100;
    localparam int          LED_STEP      = 25;

    typedef enum logic [2:0] {
        MODE_OFF_IDLE  = 3'd0,
        MODE_OFF_LEVEL = 3'd1,
        MODE_OFF_ANIM  = 3'd2,
        MODE_ON_IDLE   = 3'd3,
        MODE_ON_BLIP   = 3'd4,
        MODE_ON_LEVEL  = 3'd5,
        MODE_ON_ANIM   = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        C_IDLE,
        C_MV_MUL,
        C_MV_FOLD,
        C_PCT_GO,
        C_PCT_RUN,
        C_EMIT
    } t_ctrl_state;

    typedef struct packed {
        logic take;
        logic load_prod;
        logic load_mv;
        logic div_start;
        logic load_pct_clamp;
        logic load_pct_div;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_done;
        logic clamped;
        logic out_free;
    } t_dp_status;

    // Solid LEDs in bits 3..0, blinking LED in bits 7..4.
    function automatic logic [7:0] level_pattern(input logic [6:0] pct);
        logic [7:0] bits;
        logic [7:0] twop;
        logic [2:0] n;
        logic [2:0] solid;
        bits  = '0;
        twop  = {pct, 1'b0};
        n     = '0;
        solid = '0;
        if (pct == '0) begin
            bits = '0;
        end else if (pct >= PCT_FULL) begin
            bits = 8'h0F;
        end else begin
            for (int k = 1; k <= 7; k++) begin
                if (twop >= 8'(k * LED_STEP)) begin
                    n = 3'(k);
                end
            end
            solid     = 3'((4'(n) + 4'd1) >> 1);
            bits[3:0] = 4'((5'd1 << solid) - 5'd1);
            bits[7:4] = n[0] ? 4'd0 : 4'(5'd1 << solid);
        end
        return bits;
    endfunction

endpackage

// ===== hw/rtl/pbbg_in_if.sv =====
// Input channel: one tick with raw button level and mean ADC code.
`timescale 1ns / 1ps
interface pbbg_in_if #(
    parameter int ADC_BITS = 12
);
    logic                valid;
    logic                ready;
    logic                button_raw;
    logic [ADC_BITS-1:0] adc_mean;

    modport source (output valid, output button_raw, output adc_mean, input ready);
    modport sink   (input valid, input button_raw, input adc_mean, output ready);
endinterface

// ===== hw/rtl/pbbg_out_if.sv =====
// Output channel: power enable, indicator, level LEDs and mode per tick.
`timescale 1ns / 1ps
interface pbbg_out_if;
    logic       valid;
    logic       ready;
    logic       power_enable;
    logic       indicator;
    logic [3:0] level_leds;
    logic [2:0] mode;

    modport source (output valid, output power_enable, output indicator,
                    output level_leds, output mode, input ready);
    modport sink   (input valid, input power_enable, input indicator,
                    input level_leds, input mode, output ready);
endinterface

// ===== hw/rtl/pbbg_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pbbg_div #(
    parameter int W = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_div;

    logic [W:0]   rem_sh;
    logic         fits;
    logic [W-1:0] n_rem;

    always_comb begin
        rem_sh = {r_rem, r_quo[W-1]};
        fits   = rem_sh >= {1'b0, r_div};
        n_rem  = fits ? W'(rem_sh - {1'b0, r_div}) : rem_sh[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ===== hw/rtl/pbbg_dp.sv =====
// Datapath: configuration, debounce, power mode, timers, gauge arithmetic and result register.
`timescale 1ns / 1ps
module pbbg_dp #(
    parameter int TIMER_BITS = 16,
    parameter int ADC_BITS   = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pbbg_pkg::t_ctrl_cmd                 i_cmd,
    output pbbg_pkg::t_dp_status                o_status,
    input  logic                                i_cfg_we,
    input  logic [pbbg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pbbg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_button_raw,
    input  logic [ADC_BITS-1:0]                 i_adc_mean,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_power_enable,
    output logic                                o_indicator,
    output logic [3:0]                          o_level_leds,
    output logic [2:0]                          o_mode
);
    import pbbg_pkg::*;

    localparam int TW     = TIMER_BITS;
    localparam int CW     = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam int DIV_W  = 19;
    localparam int MV_W   = (ADC_BITS > 12) ? ADC_BITS : 12;
    localparam int PROD_W = ADC_BITS + 12;
    localparam int R1_W   = MV_W + 1;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};

    function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
        return (v == TMAX) ? v : v + TW'(1);
    endfunction

    function automatic logic ge_cfg(input logic [TW-1:0] t, input logic [15:0] c);
        return CW'(t) >= CW'(c);
    endfunction

    // configuration
    logic [15:0] r_debounce, r_window, r_long_press, r_blip, r_blink_half;
    logic [13:0] r_anim_step;
    logic [11:0] r_empty, r_full;

    // persistent state
    t_mode         r_mode;
    logic          r_raw_last, r_stable, r_swallow, r_blink_phase, r_power;
    logic [TW-1:0] r_since, r_win, r_anim, r_blip_el, r_blink_cnt;

    // per-transaction working registers
    logic [ADC_BITS-1:0] r_code;
    logic                r_phase_shown;
    logic [3:0]          r_anim_pat;
    logic [6:0]          r_pct;

    // result register
    logic       r_out_valid;
    logic       r_out_power, r_out_ind;
    logic [3:0] r_out_leds;
    logic [2:0] r_out_mode;

    t_mode         n_mode;
    logic          n_stable, n_swallow, n_blink_phase, n_power;
    logic [TW-1:0] n_since, n_win, n_anim, n_blip_el, n_blink_cnt;
    logic [3:0]    n_anim_pat;

    logic          chg, pressed, released_raw, released;
    logic [TW-1:0] blink_inc;
    logic [15:0]   s1, s2, s3, s4;
    logic [2:0]    steps;
    logic [4:0]    grow;

    always_comb begin
        n_since      = (i_button_raw != r_raw_last) ? '0 : sat_inc(r_since);
        chg          = (i_button_raw != r_stable) && ge_cfg(n_since, r_debounce);
        pressed      = chg & i_button_raw;
        released_raw = chg & ~i_button_raw;
        n_stable     = chg ? i_button_raw : r_stable;

        n_win     = sat_inc(r_win);
        n_anim    = sat_inc(r_anim);
        n_blip_el = sat_inc(r_blip_el);

        n_swallow = r_swallow;
        released  = released_raw;
        if (released_raw && r_swallow) begin
            n_swallow = 1'b0;
            released  = 1'b0;
        end

        n_mode  = r_mode;
        n_power = r_power;
        unique case (r_mode)
            MODE_OFF_IDLE: begin
                if (released) begin
                    n_mode = MODE_OFF_LEVEL;
                    n_win  = '0;
                end
            end
            MODE_OFF_LEVEL: begin
                if (pressed) begin
                    n_mode = MODE_OFF_ANIM;
                    n_anim = '0;
                end else if (ge_cfg(n_win, r_window)) begin
                    n_mode = MODE_OFF_IDLE;
                end
            end
            MODE_ON_LEVEL: begin
                if (pressed) begin
                    n_mode = MODE_ON_ANIM;
                    n_anim = '0;
                end else if (ge_cfg(n_win, r_window)) begin
                    n_mode = MODE_ON_IDLE;
                end
            end
            MODE_OFF_ANIM: begin
                if (n_stable && ge_cfg(n_anim, r_long_press)) begin
                    n_power   = 1'b1;
                    n_mode    = MODE_ON_IDLE;
                    n_swallow = 1'b1;
                end else if (released) begin
                    n_mode = MODE_OFF_LEVEL;
                end
            end
            MODE_ON_IDLE: begin
                if (released) begin
                    n_mode    = MODE_ON_BLIP;
                    n_blip_el = '0;
                end
            end
            MODE_ON_BLIP: begin
                if (ge_cfg(n_blip_el, r_blip)) begin
                    n_mode = MODE_ON_LEVEL;
                    n_win  = '0;
                end
            end
            MODE_ON_ANIM: begin
                if (n_stable && ge_cfg(n_anim, r_long_press)) begin
                    n_power   = 1'b0;
                    n_mode    = MODE_OFF_IDLE;
                    n_swallow = 1'b1;
                end else if (released) begin
                    n_mode = MODE_ON_LEVEL;
                end
            end
            default: begin
                n_mode = MODE_OFF_IDLE;
            end
        endcase

        s1 = 16'(r_anim_step);
        s2 = {1'b0, r_anim_step, 1'b0};
        s3 = s1 + s2;
        s4 = {r_anim_step, 2'b00};
        priority if (ge_cfg(n_anim, s4)) begin
            steps = 3'd4;
        end else if (ge_cfg(n_anim, s3)) begin
            steps = 3'd3;
        end else if (ge_cfg(n_anim, s2)) begin
            steps = 3'd2;
        end else if (ge_cfg(n_anim, s1)) begin
            steps = 3'd1;
        end else begin
            steps = 3'd0;
        end
        grow       = (5'd1 << steps) - 5'd1;
        n_anim_pat = (n_mode == MODE_ON_ANIM) ? (4'hF >> steps) : grow[3:0];

        blink_inc     = sat_inc(r_blink_cnt);
        n_blink_cnt   = blink_inc;
        n_blink_phase = r_blink_phase;
        if (ge_cfg(blink_inc, r_blink_half)) begin
            n_blink_cnt   = '0;
            n_blink_phase = ~r_blink_phase;
        end
    end

    // gauge arithmetic: fold the divide by 4095 into shifts and adds, divide for percent
    logic [PROD_W-1:0]   r_prod;
    logic [MV_W-1:0]     r_mv;
    logic [ADC_BITS-1:0] mv_q1;
    logic [R1_W-1:0]     mv_r1;
    logic [MV_W-12:0]    mv_q2;
    logic [12:0]         mv_r2;
    logic [MV_W-1:0]     mv_fold;
    logic [DIV_W-1:0]    div_dividend, div_divisor, div_quo;
    logic                div_done;
    logic                mv_le_empty, mv_ge_full;
    logic [11:0]         mv_diff;
    logic [18:0]         pct_num;

    always_comb begin
        mv_q1   = r_prod[PROD_W-1:12];
        mv_r1   = R1_W'(r_prod[11:0]) + R1_W'(mv_q1);
        mv_q2   = mv_r1[MV_W:12];
        mv_r2   = 13'(mv_r1[11:0]) + 13'(mv_q2);
        mv_fold = MV_W'(mv_q1) + MV_W'(mv_q2) + MV_W'(mv_r2 >= 13'(ADC_FULL_CODE));

        mv_le_empty  = r_mv <= MV_W'(r_empty);
        mv_ge_full   = r_mv >= MV_W'(r_full);
        mv_diff      = 12'(r_mv - MV_W'(r_empty));
        pct_num      = 19'(mv_diff) * 19'(PCT_FULL);
        div_dividend = DIV_W'(pct_num);
        div_divisor  = DIV_W'(r_full - r_empty);
    end

    pbbg_div #(
        .W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // render
    logic [7:0] pat;
    logic       ind;
    logic [3:0] leds;

    always_comb begin
        unique case (r_mode)
            MODE_OFF_IDLE: begin
                ind = r_stable;
                pat = '0;
            end
            MODE_OFF_LEVEL, MODE_ON_IDLE, MODE_ON_LEVEL: begin
                ind = 1'b1;
                pat = level_pattern(r_pct);
            end
            MODE_OFF_ANIM, MODE_ON_ANIM: begin
                ind = 1'b1;
                pat = {4'd0, r_anim_pat};
            end
            MODE_ON_BLIP: begin
                ind = 1'b1;
                pat = '0;
            end
            default: begin
                ind = 1'b0;
                pat = '0;
            end
        endcase
        leds = pat[3:0] | (r_phase_shown ? 4'd0 : pat[7:4]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= RST_DEBOUNCE;
            r_window      <= RST_WINDOW;
            r_long_press  <= RST_LONG_PRESS;
            r_blip        <= RST_BLIP;
            r_anim_step   <= RST_ANIM_STEP;
            r_blink_half  <= RST_BLINK_HALF;
            r_empty       <= RST_EMPTY_MV;
            r_full        <= RST_FULL_MV;
            r_mode        <= MODE_OFF_IDLE;
            r_raw_last    <= 1'b0;
            r_stable      <= 1'b0;
            r_swallow     <= 1'b0;
            r_blink_phase <= 1'b0;
            r_power       <= 1'b0;
            r_since       <= '0;
            r_win         <= '0;
            r_anim        <= '0;
            r_blip_el     <= '0;
            r_blink_cnt   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                    CFG_WINDOW:     r_window     <= i_cfg_data;
                    CFG_LONG_PRESS: r_long_press <= i_cfg_data;
                    CFG_BLIP:       r_blip       <= i_cfg_data;
                    CFG_ANIM_STEP:  r_anim_step  <= i_cfg_data[13:0];
                    CFG_BLINK_HALF: r_blink_half <= i_cfg_data;
                    CFG_EMPTY_MV:   r_empty      <= i_cfg_data[11:0];
                    CFG_FULL_MV:    r_full       <= i_cfg_data[11:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.take) begin
                r_mode        <= n_mode;
                r_raw_last    <= i_button_raw;
                r_stable      <= n_stable;
                r_swallow     <= n_swallow;
                r_blink_phase <= n_blink_phase;
                r_power       <= n_power;
                r_since       <= n_since;
                r_win         <= n_win;
                r_anim        <= n_anim;
                r_blip_el     <= n_blip_el;
                r_blink_cnt   <= n_blink_cnt;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_code        <= i_adc_mean;
            r_phase_shown <= r_blink_phase;
            r_anim_pat    <= n_anim_pat;
        end
        if (i_cmd.load_prod) begin
            r_prod <= PROD_W'(r_code) * PROD_W'(VREF_MV);
        end
        if (i_cmd.load_mv) begin
            r_mv <= mv_fold;
        end
        if (i_cmd.load_pct_clamp) begin
            r_pct <= mv_le_empty ? 7'd0 : PCT_FULL;
        end else if (i_cmd.load_pct_div) begin
            r_pct <= div_quo[6:0];
        end
        if (i_cmd.emit) begin
            r_out_power <= r_power;
            r_out_ind   <= ind;
            r_out_leds  <= leds;
            r_out_mode  <= r_mode;
        end
    end

    always_comb begin
        o_status.div_done = div_done;
        o_status.clamped  = mv_le_empty | mv_ge_full;
        o_status.out_free = ~r_out_valid | i_ready;
    end

    assign o_valid        = r_out_valid;
    assign o_power_enable = r_out_power;
    assign o_indicator    = r_out_ind;
    assign o_level_leds   = r_out_leds;
    assign o_mode         = r_out_mode;
endmodule

// ===== hw/rtl/pbbg_ctrl.sv =====
// Controller: sequences intake, millivolt scaling, the percent division and the result hand-off.
`timescale 1ns / 1ps
module pbbg_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pbbg_pkg::t_dp_status i_status,
    output pbbg_pkg::t_ctrl_cmd  o_cmd
);
    import pbbg_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (i_in_valid) n_state = C_MV_MUL;
            end
            C_MV_MUL: begin
                n_state = C_MV_FOLD;
            end
            C_MV_FOLD: begin
                n_state = C_PCT_GO;
            end
            C_PCT_GO: begin
                n_state = i_status.clamped ? C_EMIT : C_PCT_RUN;
            end
            C_PCT_RUN: begin
                if (i_status.div_done) n_state = C_EMIT;
            end
            C_EMIT: begin
                if (i_status.out_free) n_state = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            C_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            C_MV_MUL: begin
                o_cmd.load_prod = 1'b1;
            end
            C_MV_FOLD: begin
                o_cmd.load_mv = 1'b1;
            end
            C_PCT_GO: begin
                o_cmd.load_pct_clamp = i_status.clamped;
                o_cmd.div_start      = ~i_status.clamped;
            end
            C_PCT_RUN: begin
                o_cmd.load_pct_div = i_status.div_done;
            end
            C_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== hw/rtl/power_button_battery_gauge.sv =====
// Top level of the power button and battery gauge.
//
// Each input transaction on i_item is one 5 ms tick: the raw button level and
// the mean battery ADC code. Each tick yields exactly one result transaction on
// o_result: power enable, indicator, four level LEDs and the power mode.
// Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data.
// The user must write them only while no tick is in flight; the block does not
// enforce this. A write takes effect at the next clock edge. One tick at a time:
// the debounce and power mode update at acceptance, the ADC code becomes
// millivolts through a multiply, then shifts and adds for the divide by 4095,
// and the percentage comes from a restoring division. A reading between the
// empty and full voltages goes through the division; a reading clamped to 0 or
// 100 percent skips it. The result register holds a finished result while the
// receiver stalls; the next tick is accepted meanwhile and waits only at its
// own hand-off. Synchronous reset restores the register defaults, the off-idle
// mode and clears all timers and the result valid flag.
`timescale 1ns / 1ps
module power_button_battery_gauge #(
    parameter int TIMER_BITS = 16,
    parameter int ADC_BITS   = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pbbg_in_if.sink                         i_item,
    pbbg_out_if.source                      o_result,
    input  logic                            i_cfg_we,
    input  logic [pbbg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pbbg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pbbg_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    pbbg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pbbg_dp #(
        .TIMER_BITS (TIMER_BITS),
        .ADC_BITS   (ADC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_button_raw   (i_item.button_raw),
        .i_adc_mean     (i_item.adc_mean),
        .o_valid        (o_result.valid),
        .i_ready        (o_result.ready),
        .o_power_enable (o_result.power_enable),
        .o_indicator    (o_result.indicator),
        .o_level_leds   (o_result.level_leds),
        .o_mode         (o_result.mode)
    );

    assign i_item.ready = w_in_ready;
endmodule
